// ===== design/kcte_pkg.sv =====
// shared types, widths and codes for the keyed credit table
package kcte_pkg;

    localparam int KEY_W      = 32;
    localparam int CNT_W      = 31;
    localparam int TICK_W     = 32;
    localparam int ID_W       = 32;
    localparam int THR_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [CNT_W-1:0]  CNT_MAX      = '1;
    localparam logic [ID_W-1:0]   OWNER_ID_RST = 32'd20;
    localparam logic [TICK_W-1:0] LIFETIME_RST = 32'd1000;
    localparam logic [THR_W-1:0]  THR_RST      = 7'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_OWNER_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIFETIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LEVEL    = 2'd2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLAIM  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   owner_id;
        logic [TICK_W-1:0] entry_lifetime;
        logic [THR_W-1:0]  sweep_level;
    } t_cfg;

    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  item_key;
        logic [CNT_W-1:0]  amount;
        logic [ID_W-1:0]   source_id;
        logic [ID_W-1:0]   dest_id;
        logic              world_drop;
        logic [TICK_W-1:0] now_tick;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
        logic [TICK_W-1:0] time_stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [CNT_W-1:0] claimed;
        t_status          status;
    } t_result;

endpackage

// ===== design/keyed_credit_table_with_expiry.sv =====
// top level of the keyed credit table with expiry
//
// input channel: i_valid / o_stall carry one record (op 0) or claim (op 1)
// transaction; a transaction is taken when i_valid is high and o_stall low
// output channel: o_valid / i_stall carry one result (claimed, status) per
// input transaction, in order; the result is held stable while i_stall is high
// config channel: i_cfg_valid / o_cfg_ready write owner_id (0),
// entry_lifetime (1) or the sweep level (2); other indexes are dropped;
// writes are meant for idle periods only
// a claim of zero or a record that fails the filter skips the table and goes
// straight to its result; any other transaction walks every table entry
// through the ram read port, one per cycle, dropping aged ones when a record
// sweeps, then writes back at most one entry; one transaction is in work at a
// time and the next can be taken in the same cycle as o_valid rises
// after reset the table is cleared one entry per cycle with o_stall high;
// config writes are taken during that pass
// a stalled result sits in the output register while the next transaction
// is taken and worked; its own result waits until the register frees up
module keyed_credit_table_with_expiry #(
    parameter int TABLE_ENTRIES = kcte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic [kcte_pkg::KEY_W-1:0]          i_item_key,
    input  logic [kcte_pkg::CNT_W-1:0]          i_amount,
    input  logic [kcte_pkg::ID_W-1:0]           i_source_id,
    input  logic [kcte_pkg::ID_W-1:0]           i_dest_id,
    input  logic                                i_world_drop,
    input  logic [kcte_pkg::TICK_W-1:0]         i_now_tick,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [kcte_pkg::CNT_W-1:0]          o_claimed,
    output logic [1:0]                          o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kcte_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kcte_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

    kcte_pkg::t_cfg    r_cfg;
    kcte_pkg::t_item   item;
    kcte_pkg::t_result res;
    kcte_pkg::t_result r_out;
    logic              r_out_valid;
    logic              busy;
    logic              res_valid;
    logic              res_ready;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    kcte_pkg::t_entry  mem_wdata;
    kcte_pkg::t_entry  mem_rdata;
    logic [OCC_W-1:0]  occ;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.owner_id       <= kcte_pkg::OWNER_ID_RST;
            r_cfg.entry_lifetime <= kcte_pkg::LIFETIME_RST;
            r_cfg.sweep_level    <= kcte_pkg::THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kcte_pkg::CFG_OWNER_ID: begin
                    r_cfg.owner_id <= i_cfg_data;
                end
                kcte_pkg::CFG_ENTRY_LIFETIME: begin
                    r_cfg.entry_lifetime <= i_cfg_data;
                end
                kcte_pkg::CFG_SWEEP_LEVEL: begin
                    r_cfg.sweep_level <= i_cfg_data[kcte_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign item = {i_op, i_item_key, i_amount, i_source_id, i_dest_id,
                   i_world_drop, i_now_tick};

    assign o_stall   = busy;
    assign res_ready = !r_out_valid || !i_stall;

    kcte_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item_valid(i_valid),
        .i_item      (item),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_occ       (occ)
    );

    kcte_ram #(
        .WIDTH(kcte_pkg::ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_claimed = r_out.claimed;
    assign o_status  = r_out.status;

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !(r_out_valid && i_stall))
        else $error("result written over a stalled result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transaction taken while one is in work");

    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= OCC_W'(TABLE_ENTRIES))
        else $error("occupancy above table size");

    a_grant_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_claimed != '0)) |-> (o_status == kcte_pkg::ST_DONE))
        else $error("nonzero grant with a record status");

endmodule

// ===== design/kcte_ram.sv =====
// generic simple dual-port ram with registered read
module kcte_ram #(
    parameter int WIDTH = kcte_pkg::ENTRY_W,
    parameter int DEPTH = kcte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/kcte_engine.sv =====
// table engine: clearing pass, scan with sweep, read-modify-write of one entry
module kcte_engine #(
    parameter int TABLE_ENTRIES = kcte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kcte_pkg::t_cfg                   i_cfg,
    input  logic                             i_item_valid,
    input  kcte_pkg::t_item                  i_item,
    output logic                             o_busy,
    output logic                             o_res_valid,
    output kcte_pkg::t_result                o_res,
    input  logic                             i_res_ready,
    output logic                             o_mem_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_mem_waddr,
    output kcte_pkg::t_entry                 o_mem_wdata,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_mem_raddr,
    input  kcte_pkg::t_entry                 i_mem_rdata,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_occ
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CW    = AW + 1;
    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > kcte_pkg::THR_W) ? OCC_W : kcte_pkg::THR_W;
    localparam logic [CW-1:0] N_C      = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_APPLY = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ev_vld, n_ev_vld;
    logic [AW-1:0]          r_ev_idx, n_ev_idx;
    logic                   r_sweep, n_sweep;
    logic                   r_hit, n_hit;
    logic                   r_hit_exp, n_hit_exp;
    logic                   r_free, n_free;
    logic [OCC_W-1:0]       r_occ, n_occ;
    kcte_pkg::t_result      r_res, n_res;

    kcte_pkg::t_item        r_item;
    kcte_pkg::t_entry       r_hit_entry;
    logic [AW-1:0]          r_hit_slot;
    logic [AW-1:0]          r_free_slot;

    kcte_pkg::t_entry            ev;
    logic [kcte_pkg::TICK_W-1:0] age;
    logic                        ev_exp;
    logic                        sweep_hit;
    logic                        key_hit;
    logic                        free_hit;
    logic                        pass;
    logic                        do_sweep;
    logic [kcte_pkg::CNT_W:0]    sum;
    logic [kcte_pkg::CNT_W-1:0]  sat_cnt;
    logic [kcte_pkg::CNT_W-1:0]  grant;
    logic [kcte_pkg::CNT_W-1:0]  remain;
    logic                        scanning;

    assign ev        = i_mem_rdata;
    assign age       = r_item.now_tick - ev.time_stamp;
    assign ev_exp    = age > i_cfg.entry_lifetime;
    assign scanning  = (r_state == S_SCAN) && r_ev_vld;
    assign sweep_hit = scanning && r_sweep && ev.valid && ev_exp;
    assign key_hit   = scanning && ev.valid && (ev.key == r_item.item_key) && !sweep_hit;
    assign free_hit  = scanning && (!ev.valid || sweep_hit);

    assign pass = (i_item.amount != '0) && (i_item.item_key != '0) &&
                  (i_item.source_id == i_cfg.owner_id) &&
                  ((i_item.dest_id != '0) || i_item.world_drop);
    assign do_sweep = CMP_W'(r_occ) >= CMP_W'(i_cfg.sweep_level);

    assign sum     = {1'b0, r_hit_entry.count} + {1'b0, r_item.amount};
    assign sat_cnt = sum[kcte_pkg::CNT_W] ? kcte_pkg::CNT_MAX : sum[kcte_pkg::CNT_W-1:0];
    assign grant   = (r_hit_entry.count < r_item.amount) ? r_hit_entry.count : r_item.amount;
    assign remain  = r_hit_entry.count - grant;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ev_vld    = r_ev_vld;
        n_ev_idx    = r_ev_idx;
        n_sweep     = r_sweep;
        n_hit       = r_hit;
        n_hit_exp   = r_hit_exp;
        n_free      = r_free;
        n_occ       = r_occ;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ev_idx;
        o_mem_wdata = '0;
        o_mem_raddr = r_cnt[AW-1:0];
        o_res_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cnt[AW-1:0];
                n_cnt       = r_cnt + CW'(1);
                if (r_cnt[AW-1:0] == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    n_cnt    = '0;
                    n_ev_vld = 1'b0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_res    = {{kcte_pkg::CNT_W{1'b0}}, kcte_pkg::ST_DONE};
                    if (i_item.op == kcte_pkg::OP_CLAIM) begin
                        n_sweep = 1'b0;
                        n_state = (i_item.amount == '0) ? S_RESP : S_SCAN;
                    end else if (!pass) begin
                        n_res.status = kcte_pkg::ST_IGNORED;
                        n_state      = S_RESP;
                    end else begin
                        n_sweep = do_sweep;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt != N_C) begin
                    n_cnt    = r_cnt + CW'(1);
                    n_ev_vld = 1'b1;
                    n_ev_idx = r_cnt[AW-1:0];
                end else begin
                    n_ev_vld = 1'b0;
                end
                if (sweep_hit) begin
                    o_mem_we          = 1'b1;
                    o_mem_wdata       = ev;
                    o_mem_wdata.valid = 1'b0;
                    if (r_occ != '0) begin
                        n_occ = r_occ - OCC_W'(1);
                    end
                end
                if (key_hit) begin
                    n_hit     = 1'b1;
                    n_hit_exp = ev_exp;
                end
                if (free_hit) begin
                    n_free = 1'b1;
                end
                if (r_ev_vld && (r_ev_idx == LAST_IDX)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state     = S_RESP;
                o_mem_waddr = r_hit_slot;
                if (r_item.op == kcte_pkg::OP_RECORD) begin
                    if (r_hit) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {1'b1, r_item.item_key, sat_cnt, r_item.now_tick};
                    end else if (r_free) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_free_slot;
                        o_mem_wdata = {1'b1, r_item.item_key, r_item.amount, r_item.now_tick};
                        n_occ       = r_occ + OCC_W'(1);
                    end else begin
                        n_res.status = kcte_pkg::ST_FULL;
                    end
                end else if (r_hit) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = r_hit_entry;
                    if (r_hit_exp || (remain == '0)) begin
                        o_mem_wdata.valid = 1'b0;
                        if (r_occ != '0) begin
                            n_occ = r_occ - OCC_W'(1);
                        end
                    end else begin
                        o_mem_wdata.count = remain;
                    end
                    if (!r_hit_exp) begin
                        n_res.claimed = grant;
                    end
                end
            end
            S_RESP: begin
                o_res_valid = i_res_ready;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_ev_vld  <= 1'b0;
            r_ev_idx  <= '0;
            r_sweep   <= 1'b0;
            r_hit     <= 1'b0;
            r_hit_exp <= 1'b0;
            r_free    <= 1'b0;
            r_occ     <= '0;
            r_res     <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ev_vld  <= n_ev_vld;
            r_ev_idx  <= n_ev_idx;
            r_sweep   <= n_sweep;
            r_hit     <= n_hit;
            r_hit_exp <= n_hit_exp;
            r_free    <= n_free;
            r_occ     <= n_occ;
            r_res     <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_item_valid) begin
            r_item <= i_item;
        end
        if (key_hit) begin
            r_hit_entry <= ev;
            r_hit_slot  <= r_ev_idx;
        end
        if (free_hit && !r_free) begin
            r_free_slot <= r_ev_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;
    assign o_occ  = r_occ;

endmodule

// ===== test/keyed_credit_table_with_expiry_tb.sv =====
// self-checking testbench for the keyed credit table with expiry
module keyed_credit_table_with_expiry_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = kcte_pkg::TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [kcte_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class credit_scoreboard;
        logic [kcte_pkg::ID_W-1:0]   owner;
        logic [kcte_pkg::TICK_W-1:0] lifetime;
        logic [kcte_pkg::THR_W-1:0]  threshold;
        logic [kcte_pkg::KEY_W-1:0]  key_tab[ENTRIES];
        logic [kcte_pkg::CNT_W-1:0]  cnt_tab[ENTRIES];
        logic [kcte_pkg::TICK_W-1:0] stamp_tab[ENTRIES];
        bit                          live[ENTRIES];
        int                          occ;
        kcte_pkg::t_result           pending_q[$];
        int                          errors;

        function new();
            owner     = kcte_pkg::OWNER_ID_RST;
            lifetime  = kcte_pkg::LIFETIME_RST;
            threshold = kcte_pkg::THR_RST;
            foreach (live[i]) live[i] = 1'b0;
            occ    = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [kcte_pkg::CFG_IDX_W-1:0] idx,
                                logic [kcte_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                kcte_pkg::CFG_OWNER_ID:       owner = data;
                kcte_pkg::CFG_ENTRY_LIFETIME: lifetime = data;
                kcte_pkg::CFG_SWEEP_LEVEL:    threshold = data[kcte_pkg::THR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit aged(int s, logic [kcte_pkg::TICK_W-1:0] now);
            logic [kcte_pkg::TICK_W-1:0] age;
            age = now - stamp_tab[s];
            return age > lifetime;
        endfunction

        function void drop(int s);
            live[s] = 1'b0;
            if (occ > 0) occ--;
        endfunction

        function int lookup(logic [kcte_pkg::KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && key_tab[i] == key) return i;
            return -1;
        endfunction

        function void note_input(kcte_pkg::t_item it);
            kcte_pkg::t_result res;
            int s;
            logic [kcte_pkg::CNT_W:0] sum;
            res.claimed = '0;
            res.status = kcte_pkg::ST_DONE;
            if (it.op == kcte_pkg::OP_CLAIM) begin
                if (it.amount != 0) begin
                    s = lookup(it.item_key);
                    if (s >= 0) begin
                        if (aged(s, it.now_tick)) begin
                            drop(s);
                        end else begin
                            res.claimed = (cnt_tab[s] < it.amount) ? cnt_tab[s] : it.amount;
                            cnt_tab[s] = cnt_tab[s] - res.claimed;
                            if (cnt_tab[s] == 0) drop(s);
                        end
                    end
                end
            end else if (it.amount == 0 || it.item_key == 0 || it.source_id != owner ||
                         (it.dest_id == 0 && !it.world_drop)) begin
                res.status = kcte_pkg::ST_IGNORED;
            end else begin
                if (occ >= int'(threshold)) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (live[i] && aged(i, it.now_tick)) drop(i);
                end
                s = lookup(it.item_key);
                if (s >= 0) begin
                    sum = {1'b0, cnt_tab[s]} + {1'b0, it.amount};
                    cnt_tab[s] = (sum > {1'b0, kcte_pkg::CNT_MAX}) ?
                                 kcte_pkg::CNT_MAX : sum[kcte_pkg::CNT_W-1:0];
                    stamp_tab[s] = it.now_tick;
                end else begin
                    res.status = kcte_pkg::ST_FULL;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!live[i]) begin
                            live[i] = 1'b1;
                            key_tab[i] = it.item_key;
                            cnt_tab[i] = it.amount;
                            stamp_tab[i] = it.now_tick;
                            occ++;
                            res.status = kcte_pkg::ST_DONE;
                            break;
                        end
                    end
                end
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [kcte_pkg::CNT_W-1:0] claimed, logic [1:0] status);
            kcte_pkg::t_result exp_res;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: claimed %0d status %0d", claimed, status);
                return;
            end
            exp_res = pending_q.pop_front();
            if (claimed !== exp_res.claimed || status !== exp_res.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: claimed exp %0d got %0d, status exp %0d got %0d",
                             exp_res.claimed, claimed, exp_res.status, status);
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic                            i_op = kcte_pkg::OP_RECORD;
    logic [kcte_pkg::KEY_W-1:0]      i_item_key = '0;
    logic [kcte_pkg::CNT_W-1:0]      i_amount = '0;
    logic [kcte_pkg::ID_W-1:0]       i_source_id = '0;
    logic [kcte_pkg::ID_W-1:0]       i_dest_id = '0;
    logic                            i_world_drop = 1'b0;
    logic [kcte_pkg::TICK_W-1:0]     i_now_tick = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [kcte_pkg::CNT_W-1:0]      o_claimed;
    logic [1:0]                      o_status;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [kcte_pkg::CFG_IDX_W-1:0]  i_cfg_index = kcte_pkg::CFG_OWNER_ID;
    logic [kcte_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    credit_scoreboard            sb;
    bit                          calm = 1'b0;
    int                          cycles = 0;
    logic [kcte_pkg::TICK_W-1:0] tick_now = 32'd2000;

    keyed_credit_table_with_expiry i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_item_key  (i_item_key),
        .i_amount    (i_amount),
        .i_source_id (i_source_id),
        .i_dest_id   (i_dest_id),
        .i_world_drop(i_world_drop),
        .i_now_tick  (i_now_tick),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_claimed   (o_claimed),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check each result as it is taken, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_claimed, o_status);
        i_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    function automatic kcte_pkg::t_item build(logic op, logic [kcte_pkg::KEY_W-1:0] key,
                                              logic [kcte_pkg::CNT_W-1:0] amt,
                                              logic [kcte_pkg::ID_W-1:0] src,
                                              logic [kcte_pkg::ID_W-1:0] dst, logic wd,
                                              logic [kcte_pkg::TICK_W-1:0] now);
        kcte_pkg::t_item it;
        it.op = op;
        it.item_key = key;
        it.amount = amt;
        it.source_id = src;
        it.dest_id = dst;
        it.world_drop = wd;
        it.now_tick = now;
        return it;
    endfunction

    task automatic send_item(input kcte_pkg::t_item it);
        if (!i_valid) i_valid <= 1'b1;
        i_op <= it.op;
        i_item_key <= it.item_key;
        i_amount <= it.amount;
        i_source_id <= it.source_id;
        i_dest_id <= it.dest_id;
        i_world_drop <= it.world_drop;
        i_now_tick <= it.now_tick;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(it);
        if (!calm && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge i_clk);
        end
    endtask

    task automatic program_regs(input logic [kcte_pkg::ID_W-1:0] own,
                                input logic [kcte_pkg::TICK_W-1:0] life,
                                input logic [kcte_pkg::THR_W-1:0] thr, input bit extra);
        logic [kcte_pkg::CFG_IDX_W-1:0]  idxs[4];
        logic [kcte_pkg::CFG_DATA_W-1:0] vals[4];
        int n;
        idxs = '{kcte_pkg::CFG_OWNER_ID, kcte_pkg::CFG_ENTRY_LIFETIME,
                 kcte_pkg::CFG_SWEEP_LEVEL, CFG_UNUSED};
        vals = '{own, life, {{(kcte_pkg::CFG_DATA_W-kcte_pkg::THR_W){1'b0}}, thr}, $urandom};
        n = extra ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            if (!i_cfg_valid) i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idxs[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [kcte_pkg::ID_W-1:0] own,
                             input logic [kcte_pkg::TICK_W-1:0] life,
                             input logic [kcte_pkg::THR_W-1:0] thr, input int count,
                             input int pool, input int step, input bit quiet,
                             input bit extra);
        kcte_pkg::t_item it;
        logic [kcte_pkg::KEY_W-1:0] base;
        int roll;
        program_regs(own, life, thr, extra);
        calm = quiet;
        base = $urandom;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // noise transaction
                it = build(1'($urandom_range(0, 1)), $urandom, kcte_pkg::CNT_W'($urandom),
                           $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
            end else begin
                it.op = ($urandom_range(0, 99) < 35) ? kcte_pkg::OP_CLAIM : kcte_pkg::OP_RECORD;
                it.item_key = base + kcte_pkg::KEY_W'($urandom_range(0, pool - 1));
                if (it.item_key == 0) it.item_key = 1;
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    it.amount = '0;
                else if (roll < 7)
                    it.amount = kcte_pkg::CNT_MAX - kcte_pkg::CNT_W'($urandom_range(0, 100));
                else
                    it.amount = kcte_pkg::CNT_W'($urandom_range(1,
                                    it.op == kcte_pkg::OP_CLAIM ? 3000 : 1000));
                it.source_id = ($urandom_range(0, 99) < 93) ? own : kcte_pkg::ID_W'($urandom);
                it.dest_id = ($urandom_range(0, 99) < 75) ? kcte_pkg::ID_W'($urandom) : '0;
                it.world_drop = 1'($urandom_range(0, 1));
                tick_now = tick_now + kcte_pkg::TICK_W'($urandom_range(0, step));
                it.now_tick = tick_now;
            end
            send_item(it);
        end
        drain();
        calm = 1'b0;
    endtask

    initial begin
        kcte_pkg::t_item directed[$];
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // filter rejects
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd0, 31'd5, 32'd20, 32'd3, 1'b0,
                                 32'd100));
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd1, 31'd0, 32'd20, 32'd3, 1'b0,
                                 32'd100));
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd1, 31'd5, 32'hFFFF_FFFF, 32'd3,
                                 1'b0, 32'd100));
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd1, 31'd5, 32'd20, 32'd0, 1'b0,
                                 32'd100));
        // world drop and saturation
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd1, 31'd5, 32'd20, 32'd0, 1'b1,
                                 32'd100));
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd2, kcte_pkg::CNT_MAX, 32'd20,
                                 32'hFFFF_FFFF, 1'b0, 32'd100));
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd2, kcte_pkg::CNT_MAX, 32'd20,
                                 32'd9, 1'b1, 32'd200));
        // claims: zero, unknown, partial, draining, expired
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'd2, 31'd0, 32'd0, 32'd0, 1'b0,
                                 32'd250));
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'd77, 31'd10, 32'd0, 32'd0, 1'b0,
                                 32'd250));
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'd1, 31'd3, 32'd0, 32'd0, 1'b0,
                                 32'd300));
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'd1, 31'd10, 32'd0, 32'd0, 1'b0,
                                 32'd300));
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'd2, kcte_pkg::CNT_MAX, 32'd0, 32'd0,
                                 1'b0, 32'd1201));
        // tick wrap and lifetime boundary
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'hFFFF_FFFF, 31'd1, 32'd20, 32'd1,
                                 1'b0, 32'hFFFF_FFF0));
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'hFFFF_FFFF, kcte_pkg::CNT_MAX,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0010));
        directed.push_back(build(kcte_pkg::OP_RECORD, 32'd3, 31'd7, 32'd20, 32'd4, 1'b1,
                                 32'd500));
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'd3, 31'd7, 32'd0, 32'd0, 1'b0,
                                 32'd1500));
        directed.push_back(build(kcte_pkg::OP_CLAIM, 32'd3, 31'd7, 32'd0, 32'd0, 1'b0,
                                 32'd1500));
        foreach (directed[i]) send_item(directed[i]);
        drain();

        run_phase(32'd20, 32'd1000, 7'd32, 200, 40, 60, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd0, 7'd0, 150, 20, 2, 1'b0, 1'b0);
        run_phase(32'd0, 32'hFFFF_FFFF, 7'd127, 250, 100, 1000, 1'b0, 1'b1);
        run_phase($urandom, 32'd500, 7'd1, 200, 70, 40, 1'b1, 1'b0);
        tick_now = 32'hFFFF_F000;
        run_phase($urandom, $urandom_range(200, 5000), 7'd64, 250, 90, 100, 1'b0, 1'b0);
        run_phase($urandom, 32'd2000, 7'd65, 200, 80, 30, 1'b0, 1'b0);

        repeat (ENTRIES + 8) @(posedge i_clk);
        if (sb.pending_q.size() != 0) begin
            sb.errors += sb.pending_q.size();
            $display("%0d expected results never arrived", sb.pending_q.size());
        end
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== keyed_credit_table_with_expiry.f =====
design/kcte_pkg.sv
design/kcte_ram.sv
design/kcte_engine.sv
design/keyed_credit_table_with_expiry.sv
test/keyed_credit_table_with_expiry_tb.sv
